[sv/ocrm_pkg.sv]
// Shared types and constants for the overload crash/recover monitor.
package ocrm_pkg;

   // Item kind carried on the request tuser
   typedef enum logic [1:0] {
      OP_ARRIVAL = 2'd0,
      OP_TICK    = 2'd1,
      OP_CRASH   = 2'd2,
      OP_RECOVER = 2'd3
   } opcode_type;

   // Up/crashed state
   typedef enum logic {
      ST_UP      = 1'b0,
      ST_CRASHED = 1'b1
   } state_type;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AUTO_CRASH_ENABLE  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OVERLOAD_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OVERLOAD_WINDOWS   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECOVERY_SECONDS   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ATTACK_PORT        = 3'd4;

   // Register reset values
   localparam logic        RST_AUTO_CRASH_ENABLE  = 1'b0;
   localparam logic [15:0] RST_OVERLOAD_THRESHOLD = 16'd60;
   localparam logic [7:0]  RST_OVERLOAD_WINDOWS   = 8'd2;
   localparam logic [15:0] RST_RECOVERY_SECONDS   = 16'd10;
   localparam logic [15:0] RST_ATTACK_PORT        = 16'd9003;

   localparam int unsigned RSP_DATA_BITS = 56;

   // Configuration seen by the core
   typedef struct packed {
      logic        auto_crash_enable;
      logic [15:0] overload_threshold;
      logic [7:0]  overload_windows;
      logic [15:0] recovery_seconds;
      logic [15:0] attack_port;
   } cfg_type;

   // One result word
   typedef struct packed {
      logic        is_crashed;
      logic        recover_now;
      logic        crash_now;
      logic [15:0] window_packets;
      logic [31:0] sequence_number;
      logic        is_attack;
      logic        packet_accepted;
   } result_type;

endpackage

[sv/ocrm_core.sv]
// Monitor state and single-pass per-word update logic.
module ocrm_core #(
   parameter int unsigned WINDOW_COUNT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  ocrm_pkg::opcode_type   opcode,
   input  logic [15:0]            src_port,
   input  ocrm_pkg::cfg_type      cfg,
   output ocrm_pkg::result_type   result
);

   localparam logic [WINDOW_COUNT_BITS-1:0] WinMax = {WINDOW_COUNT_BITS{1'b1}};
   localparam logic [WINDOW_COUNT_BITS-1:0] WinOne = {{(WINDOW_COUNT_BITS-1){1'b0}}, 1'b1};

   ocrm_pkg::state_type            state_ff, state_in;
   logic [WINDOW_COUNT_BITS-1:0]   window_count_ff, window_count_in;
   logic [7:0]                     over_run_ff, over_run_in;
   logic [15:0]                    recovery_left_ff, recovery_left_in;
   logic [31:0]                    packet_sequence_ff, packet_sequence_in;

   logic [31:0] closed_ext;
   logic [7:0]  run_next;
   logic        accepted, attack, crash_now, recover_now;
   logic [15:0] win;

   assign closed_ext = 32'(window_count_ff);

   // Next state and datapath for the word being accepted
   always_comb begin
      state_in           = state_ff;
      window_count_in    = window_count_ff;
      over_run_in        = over_run_ff;
      recovery_left_in   = recovery_left_ff;
      packet_sequence_in = packet_sequence_ff;
      accepted           = 1'b0;
      attack             = 1'b0;
      crash_now          = 1'b0;
      recover_now        = 1'b0;
      win                = 16'd0;
      run_next           = 8'd0;
      case (opcode)
         ocrm_pkg::OP_ARRIVAL: begin
            if (state_ff == ocrm_pkg::ST_UP) begin
               accepted = 1'b1;
               if (window_count_ff != WinMax) begin
                  window_count_in = window_count_ff + WinOne;
               end
               packet_sequence_in = packet_sequence_ff + 32'd1;
               attack = (src_port == cfg.attack_port);
            end
         end
         ocrm_pkg::OP_TICK: begin
            window_count_in = '0;
            win = (closed_ext > 32'h0000_FFFF) ? 16'hFFFF : closed_ext[15:0];
            if (state_ff == ocrm_pkg::ST_CRASHED) begin
               // countdown; zero means no countdown running
               if (recovery_left_ff != 16'd0) begin
                  recovery_left_in = recovery_left_ff - 16'd1;
                  if (recovery_left_ff == 16'd1) begin
                     state_in        = ocrm_pkg::ST_UP;
                     window_count_in = '0;
                     over_run_in     = 8'd0;
                     recover_now     = 1'b1;
                  end
               end
            end else if (cfg.auto_crash_enable) begin
               if (closed_ext > 32'(cfg.overload_threshold)) begin
                  run_next = (over_run_ff != 8'hFF) ? over_run_ff + 8'd1 : over_run_ff;
               end else begin
                  run_next = 8'd0;
               end
               over_run_in = run_next;
               if (run_next >= cfg.overload_windows) begin
                  state_in         = ocrm_pkg::ST_CRASHED;
                  recovery_left_in = cfg.recovery_seconds;
                  crash_now        = 1'b1;
               end
            end
         end
         ocrm_pkg::OP_CRASH: begin
            if (state_ff == ocrm_pkg::ST_UP) begin
               state_in         = ocrm_pkg::ST_CRASHED;
               recovery_left_in = cfg.recovery_seconds;
               crash_now        = 1'b1;
            end
         end
         ocrm_pkg::OP_RECOVER: begin
            if (state_ff == ocrm_pkg::ST_CRASHED) begin
               state_in         = ocrm_pkg::ST_UP;
               recovery_left_in = 16'd0;
               window_count_in  = '0;
               over_run_in      = 8'd0;
               recover_now      = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Result word
   always_comb begin
      result.packet_accepted = accepted;
      result.is_attack       = attack;
      result.sequence_number = accepted ? packet_sequence_in : 32'd0;
      result.window_packets  = win;
      result.crash_now       = crash_now;
      result.recover_now     = recover_now;
      result.is_crashed      = (state_in == ocrm_pkg::ST_CRASHED);
   end

   // State registers, updated only when a word is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ocrm_pkg::ST_UP;
         window_count_ff    <= '0;
         over_run_ff        <= 8'd0;
         recovery_left_ff   <= 16'd0;
         packet_sequence_ff <= 32'd0;
      end else if (fire) begin
         state_ff           <= state_in;
         window_count_ff    <= window_count_in;
         over_run_ff        <= over_run_in;
         recovery_left_ff   <= recovery_left_in;
         packet_sequence_ff <= packet_sequence_in;
      end
   end

endmodule

[sv/overload_crash_recover_monitor_top.sv]
// Top level of the packet-rate overload monitor with crash and recovery.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------------
//  req     | in        | req_tvalid/req_tready  | tuser: opcode; tdata: src_port
//  rsp     | out       | rsp_tvalid/rsp_tready  | tdata: one result word per request word
//  csr     | in        | csr_valid/csr_ready    | csr_index, csr_wdata (always ready)
//
// One word per cycle; a result appears in rsp_tdata in the cycle after its request word
// is taken. The state update and result are one level of logic in front of the
// result register. req_tready drops only while a result is held by rsp_tready low.
// Synchronous active-high reset clears the state and loads register defaults.
module overload_crash_recover_monitor_top #(
   parameter int unsigned WINDOW_COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] src_port
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   // result
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [ocrm_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // [0] packet_accepted, [1] is_attack, [33:2] sequence_number,
   // [49:34] window_packets, [50] crash_now, [51] recover_now, [52] is_crashed, [55:53] 0
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [ocrm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [15:0] csr_wdata
);

   ocrm_pkg::cfg_type    cfg_ff;
   ocrm_pkg::result_type result;
   logic                 fire;
   logic                 rsp_valid_ff;
   logic [ocrm_pkg::RSP_DATA_BITS-1:0] rsp_data_ff;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.auto_crash_enable  <= ocrm_pkg::RST_AUTO_CRASH_ENABLE;
         cfg_ff.overload_threshold <= ocrm_pkg::RST_OVERLOAD_THRESHOLD;
         cfg_ff.overload_windows   <= ocrm_pkg::RST_OVERLOAD_WINDOWS;
         cfg_ff.recovery_seconds   <= ocrm_pkg::RST_RECOVERY_SECONDS;
         cfg_ff.attack_port        <= ocrm_pkg::RST_ATTACK_PORT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ocrm_pkg::CSR_AUTO_CRASH_ENABLE:  cfg_ff.auto_crash_enable  <= csr_wdata[0];
            ocrm_pkg::CSR_OVERLOAD_THRESHOLD: cfg_ff.overload_threshold <= csr_wdata;
            ocrm_pkg::CSR_OVERLOAD_WINDOWS:   cfg_ff.overload_windows   <= csr_wdata[7:0];
            ocrm_pkg::CSR_RECOVERY_SECONDS:   cfg_ff.recovery_seconds   <= csr_wdata;
            ocrm_pkg::CSR_ATTACK_PORT:        cfg_ff.attack_port        <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   ocrm_core #(
      .WINDOW_COUNT_BITS (WINDOW_COUNT_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .opcode   (ocrm_pkg::opcode_type'(req_tuser)),
      .src_port (req_tdata),
      .cfg      (cfg_ff),
      .result   (result)
   );

   // Result register; refilled whenever a request word is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= {3'b000, result.is_crashed, result.recover_now, result.crash_now,
                         result.window_packets, result.sequence_number,
                         result.is_attack, result.packet_accepted};
      end
   end

endmodule

[tb/sv/overload_crash_recover_monitor_top_tb.sv]
// Self-checking testbench for the overload crash/recover monitor top level.
module overload_crash_recover_monitor_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Predicts each result word from the requests taken and checks the words received
   class crash_monitor_scoreboard;
      ocrm_pkg::cfg_type      cfg;
      ocrm_pkg::state_type    st;
      logic [15:0]            win_cnt;
      logic [7:0]             over_run;
      logic [15:0]            recov_left;
      logic [31:0]            pkt_seq;
      ocrm_pkg::result_type   pending_results[$];
      int unsigned            errors;

      function new();
         cfg.auto_crash_enable  = ocrm_pkg::RST_AUTO_CRASH_ENABLE;
         cfg.overload_threshold = ocrm_pkg::RST_OVERLOAD_THRESHOLD;
         cfg.overload_windows   = ocrm_pkg::RST_OVERLOAD_WINDOWS;
         cfg.recovery_seconds   = ocrm_pkg::RST_RECOVERY_SECONDS;
         cfg.attack_port        = ocrm_pkg::RST_ATTACK_PORT;
         st         = ocrm_pkg::ST_UP;
         win_cnt    = '0;
         over_run   = '0;
         recov_left = '0;
         pkt_seq    = '0;
         errors     = 0;
      endfunction

      // Register write; indexes past the list are dropped
      function void write_register(logic [ocrm_pkg::CSR_INDEX_BITS-1:0] idx,
                                   logic [15:0] wdata);
         case (idx)
            ocrm_pkg::CSR_AUTO_CRASH_ENABLE:  cfg.auto_crash_enable  = wdata[0];
            ocrm_pkg::CSR_OVERLOAD_THRESHOLD: cfg.overload_threshold = wdata;
            ocrm_pkg::CSR_OVERLOAD_WINDOWS:   cfg.overload_windows   = wdata[7:0];
            ocrm_pkg::CSR_RECOVERY_SECONDS:   cfg.recovery_seconds   = wdata;
            ocrm_pkg::CSR_ATTACK_PORT:        cfg.attack_port        = wdata;
            default: ;
         endcase
      endfunction

      function void go_down();
         st         = ocrm_pkg::ST_CRASHED;
         recov_left = cfg.recovery_seconds;
      endfunction

      // Any recovery clears the countdown and the overload tracking
      function void go_up();
         st         = ocrm_pkg::ST_UP;
         recov_left = '0;
         win_cnt    = '0;
         over_run   = '0;
      endfunction

      // Update the state for one request word and queue the result it causes
      function void predict_word(ocrm_pkg::opcode_type op, logic [15:0] port);
         ocrm_pkg::result_type r;
         logic [15:0]          closed;
         r = '0;
         case (op)
            ocrm_pkg::OP_ARRIVAL: begin
               if (st == ocrm_pkg::ST_UP) begin
                  r.packet_accepted = 1'b1;
                  if (win_cnt != 16'hFFFF) win_cnt = win_cnt + 16'd1;
                  pkt_seq           = pkt_seq + 32'd1;
                  r.sequence_number = pkt_seq;
                  r.is_attack       = (port == cfg.attack_port);
               end
            end
            ocrm_pkg::OP_TICK: begin
               closed           = win_cnt;
               win_cnt          = '0;
               r.window_packets = closed;
               if (st == ocrm_pkg::ST_CRASHED) begin
                  // countdown only runs when nonzero; zero means stay down
                  if (recov_left != 0) begin
                     recov_left = recov_left - 16'd1;
                     if (recov_left == 0) begin
                        go_up();
                        r.recover_now = 1'b1;
                     end
                  end
               end else if (cfg.auto_crash_enable) begin
                  if (closed > cfg.overload_threshold) begin
                     if (over_run != 8'hFF) over_run = over_run + 8'd1;
                  end else begin
                     over_run = '0;
                  end
                  if (over_run >= cfg.overload_windows) begin
                     go_down();
                     r.crash_now = 1'b1;
                  end
               end
            end
            ocrm_pkg::OP_CRASH: begin
               if (st == ocrm_pkg::ST_UP) begin
                  go_down();
                  r.crash_now = 1'b1;
               end
            end
            default: begin
               if (st == ocrm_pkg::ST_CRASHED) begin
                  go_up();
                  r.recover_now = 1'b1;
               end
            end
         endcase
         r.is_crashed = (st == ocrm_pkg::ST_CRASHED);
         pending_results.insert(pending_results.size(), r);
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
         if (seen !== want) begin
            errors++;
            if (errors <= 50)
               $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, seen);
         end
      endfunction

      function void check_result(logic [ocrm_pkg::RSP_DATA_BITS-1:0] word);
         ocrm_pkg::result_type want;
         ocrm_pkg::result_type got;
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 50)
               $display("%0t: result word %h with none expected, expected none actual %h",
                        $time, word, word);
            return;
         end
         want = pending_results.pop_front();
         got  = word[$bits(ocrm_pkg::result_type)-1:0];
         compare_field("packet_accepted", want.packet_accepted, got.packet_accepted);
         compare_field("is_attack", want.is_attack, got.is_attack);
         compare_field("sequence_number", want.sequence_number, got.sequence_number);
         compare_field("window_packets", want.window_packets, got.window_packets);
         compare_field("crash_now", want.crash_now, got.crash_now);
         compare_field("recover_now", want.recover_now, got.recover_now);
         compare_field("is_crashed", want.is_crashed, got.is_crashed);
         compare_field("pad bits", '0,
                       word[ocrm_pkg::RSP_DATA_BITS-1:$bits(ocrm_pkg::result_type)]);
      endfunction
   endclass

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [15:0]                         req_tdata  = '0;
   logic [1:0]                          req_tuser  = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [ocrm_pkg::RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                                csr_valid  = 1'b0;
   logic                                csr_ready;
   logic [ocrm_pkg::CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [15:0]                         csr_wdata  = '0;

   crash_monitor_scoreboard sb = new();

   bit          tx_gaps_on  = 1'b1;
   bit          rx_gaps_on  = 1'b1;
   int unsigned hold_cycles = 0;

   overload_crash_recover_monitor_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Mostly no gap, short gaps often, a long one now and then
   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 99) < 70) return 0;
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [15:0] pick_port();
      case ($urandom_range(0, 5))
         0: return sb.cfg.attack_port;
         1: return 16'h0000;
         2: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Offer one request word, optionally after a gap; valid stays high afterwards
   task automatic send_word(ocrm_pkg::opcode_type op, logic [15:0] port);
      int unsigned gap;
      gap = tx_gaps_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= port;
      do @(posedge clock); while (!req_tready);
      sb.predict_word(op, port);
   endtask

   // Stop offering and wait until every expected word is back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Register write; csr_valid is left high for back-to-back writes
   task automatic write_csr(logic [ocrm_pkg::CSR_INDEX_BITS-1:0] idx, logic [15:0] wdata);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wdata;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(idx, wdata);
   endtask

   // Idle the block, then write every register (junk above the narrow ones)
   task automatic load_settings(logic ae, logic [15:0] thr, logic [7:0] nwin,
                                logic [15:0] rec, logic [15:0] port);
      logic [15:0]                         junk;
      logic [ocrm_pkg::CSR_INDEX_BITS-1:0] spare;
      int unsigned                         spare_idx;
      drain();
      junk = 16'($urandom);
      write_csr(ocrm_pkg::CSR_AUTO_CRASH_ENABLE, {junk[15:1], ae});
      write_csr(ocrm_pkg::CSR_OVERLOAD_THRESHOLD, thr);
      write_csr(ocrm_pkg::CSR_OVERLOAD_WINDOWS, {junk[15:8], nwin});
      write_csr(ocrm_pkg::CSR_RECOVERY_SECONDS, rec);
      write_csr(ocrm_pkg::CSR_ATTACK_PORT, port);
      // unused index must leave the registers alone
      if ($urandom_range(0, 1) == 1) begin
         spare_idx = ocrm_pkg::CSR_ATTACK_PORT + 1 + $urandom_range(0, 2);
         spare     = spare_idx[ocrm_pkg::CSR_INDEX_BITS-1:0];
         write_csr(spare, 16'($urandom));
      end
      csr_valid <= 1'b0;
   endtask

   // Windows of arrivals closed by ticks, with forced events and noise mixed in
   task automatic random_traffic(int unsigned n_items);
      int unsigned sent;
      int unsigned roll;
      int unsigned cap;
      int unsigned burst;
      sent = 0;
      while (sent < n_items) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            send_word(ocrm_pkg::opcode_type'($urandom_range(0, 3)), 16'($urandom));
            sent++;
         end else if (roll < 14) begin
            send_word(($urandom_range(0, 1) == 1) ? ocrm_pkg::OP_CRASH : ocrm_pkg::OP_RECOVER,
                      16'($urandom));
            sent++;
         end else begin
            cap   = (sb.cfg.overload_threshold > 10) ? 24 : 2 * sb.cfg.overload_threshold + 3;
            burst = $urandom_range(0, cap);
            repeat (burst) send_word(ocrm_pkg::OP_ARRIVAL, pick_port());
            send_word(ocrm_pkg::OP_TICK, 16'($urandom));
            sent += burst + 1;
         end
      end
   endtask

   // Result side: random stalls, plus a long hold-off when asked
   initial begin : rsp_sink
      int unsigned stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (hold_cycles != 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (stall != 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall = rx_gaps_on ? pick_gap() : 0;
         end
      end
   end

   // Stimulus
   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: arrivals, attack match, forced events both ways
      send_word(ocrm_pkg::OP_ARRIVAL, 16'h0000);
      send_word(ocrm_pkg::OP_ARRIVAL, 16'hFFFF);
      send_word(ocrm_pkg::OP_ARRIVAL, ocrm_pkg::RST_ATTACK_PORT);
      send_word(ocrm_pkg::OP_TICK, 16'h0000);
      send_word(ocrm_pkg::OP_RECOVER, 16'h0000);
      send_word(ocrm_pkg::OP_CRASH, 16'hFFFF);
      send_word(ocrm_pkg::OP_CRASH, 16'h0000);
      send_word(ocrm_pkg::OP_ARRIVAL, ocrm_pkg::RST_ATTACK_PORT);
      send_word(ocrm_pkg::OP_TICK, 16'hFFFF);
      send_word(ocrm_pkg::OP_RECOVER, 16'hFFFF);
      send_word(ocrm_pkg::OP_ARRIVAL, ocrm_pkg::RST_ATTACK_PORT);

      // zero run length crashes on any tick; zero recovery never comes back on a tick
      load_settings(1'b1, 16'd0, 8'd0, 16'd0, 16'hFFFF);
      send_word(ocrm_pkg::OP_TICK, 16'h0000);
      send_word(ocrm_pkg::OP_TICK, 16'h0000);
      send_word(ocrm_pkg::OP_TICK, 16'h0000);
      send_word(ocrm_pkg::OP_ARRIVAL, 16'hFFFF);
      send_word(ocrm_pkg::OP_RECOVER, 16'h0000);

      // crash on a tick, countdown starts on the following tick
      load_settings(1'b1, 16'd1, 8'd1, 16'd1, 16'h0000);
      send_word(ocrm_pkg::OP_ARRIVAL, 16'h0000);
      send_word(ocrm_pkg::OP_ARRIVAL, 16'd5);
      send_word(ocrm_pkg::OP_TICK, 16'h0000);
      send_word(ocrm_pkg::OP_TICK, 16'h0000);
      send_word(ocrm_pkg::OP_CRASH, 16'h0000);
      send_word(ocrm_pkg::OP_TICK, 16'h0000);

      // window counted before a forced crash is still reported
      load_settings(1'b0, 16'd60, 8'd2, 16'd3, ocrm_pkg::RST_ATTACK_PORT);
      send_word(ocrm_pkg::OP_ARRIVAL, 16'd1);
      send_word(ocrm_pkg::OP_ARRIVAL, 16'd2);
      send_word(ocrm_pkg::OP_CRASH, 16'h0000);
      send_word(ocrm_pkg::OP_TICK, 16'h0000);

      // random rounds over several settings, extremes first
      for (int round = 0; round < 6; round++) begin
         tx_gaps_on = ($urandom_range(0, 3) != 0);
         rx_gaps_on = ($urandom_range(0, 3) != 0);
         case (round)
            0: load_settings(1'b1, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
            1: load_settings(1'b0, 16'h0000, 8'h00, 16'h0000, 16'h0000);
            default: load_settings($urandom_range(0, 3) != 0,
                                   ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(0, 8)),
                                   8'($urandom_range(0, 4)),
                                   16'($urandom_range(0, 6)),
                                   16'($urandom));
         endcase
         // result side holds off while the sender keeps offering
         if (round == 2) begin
            tx_gaps_on  = 1'b0;
            hold_cycles = 300;
         end
         random_traffic(140);
      end

      // longest overload run: 255 overloaded windows before the crash
      tx_gaps_on = 1'b1;
      rx_gaps_on = 1'b1;
      load_settings(1'b1, 16'd0, 8'hFF, 16'd1, 16'($urandom));
      repeat (258) begin
         send_word(ocrm_pkg::OP_ARRIVAL, pick_port());
         send_word(ocrm_pkg::OP_TICK, 16'($urandom));
      end

      // full rate on both sides
      tx_gaps_on = 1'b0;
      rx_gaps_on = 1'b0;
      random_traffic(60);

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Run limit
   initial begin : watchdog
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
